// File: rtl/variable_rate_sample_player_defines.svh
// Assertion macros for the variable rate sample player.
`ifndef VARIABLE_RATE_SAMPLE_PLAYER_DEFINES_SVH
`define VARIABLE_RATE_SAMPLE_PLAYER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VRSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VRSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/vrsp_pkg.sv
// Shared types and constants for the variable rate sample player.
`timescale 1ns / 1ps

package vrsp_pkg;

    localparam int STORE_DEPTH  = 65536;
    localparam int ADDR_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int LEN_W        = 17;
    localparam int SPEED_W      = 24;
    localparam int POS_W        = 32;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam int DEF_SKIP_LIMIT = 600;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [LEN_W-1:0]   LENGTH_RESET = '0;
    localparam logic [SPEED_W-1:0] SPEED_RESET  = 24'd65536;

    // register select (paddr bit 2)
    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_SPEED  = 1'b1;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [ADDR_W-1:0]          write_addr;
        logic signed [SAMPLE_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       is_playing;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK_RD,
        S_SEEK_CHK,
        S_TICK_RD1,
        S_TICK_RD2,
        S_TICK_MUL,
        S_TICK_SUM,
        S_RESULT
    } t_state;

endpackage

// File: rtl/variable_rate_sample_player.sv
// Variable rate sample player: sample store, start search and interpolating playback.
//
//  channel   direction  signals                             payload
//  in        sink       i_in_valid / o_in_stall             vrsp_pkg::t_in_item
//  out       source     o_out_valid / i_out_stall           vrsp_pkg::t_out_item
//  config    APB slave  psel penable pwrite paddr pwdata     length @0, speed @4
//
// Write item: taken in the idle state. Tick: transfer, two reads of the single-port store, one
// multiply stage, one add stage, result load; an ending tick goes straight to result load and
// a tick while stopped is dropped. Start item: n entries visited (at most min(length, SKIP_LIMIT),
// min 1); each entry costs a store read and a compare.
// Reset is synchronous; the store itself is not cleared.
// A result waits in the output register under stall; new items are taken meanwhile
// until the next result needs the register.
`timescale 1ns / 1ps
`include "variable_rate_sample_player_defines.svh"

module variable_rate_sample_player #(
    parameter int SKIP_LIMIT = vrsp_pkg::DEF_SKIP_LIMIT,
    parameter int FRAC_BITS  = vrsp_pkg::DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  vrsp_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output vrsp_pkg::t_out_item        o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vrsp_pkg::APB_AW-1:0] paddr,
    input  logic [vrsp_pkg::APB_DW-1:0] pwdata,
    output logic [vrsp_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import vrsp_pkg::*;

    localparam int P_W    = (SKIP_LIMIT < 2) ? 1 : $clog2(SKIP_LIMIT + 1);
    localparam int IPOS_W = POS_W - FRAC_BITS;
    localparam int CMP_W  = IPOS_W + 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam logic [LEN_W-1:0] SKIP_LEN = LEN_W'(SKIP_LIMIT);

    // sample store
    logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;

    // control and datapath registers
    t_state                     r_state, n_state;
    logic [LEN_W-1:0]           r_length;
    logic [SPEED_W-1:0]         r_speed;
    logic [POS_W-1:0]           r_pos;
    logic                       r_active;
    logic [P_W-1:0]             r_p;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_res_sample;
    logic                       r_res_play;
    logic                       r_out_valid;
    t_out_item                  r_out_data;

    logic                       in_xfer;
    logic                       cfg_wr;
    logic                       out_load;
    logic [IPOS_W-1:0]          ipos;
    logic [FRAC_BITS-1:0]       frac;
    logic                       tick_end;
    logic [LEN_W-1:0]           seek_limit;
    logic [LEN_W-1:0]           p_next;
    logic signed [SAMPLE_W-1:0] cur;
    logic                       seek_hit;
    logic                       seek_done;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [NUM_W-1:0]    num;
    logic [NUM_W-1:0]           num_rnd;
    logic [POS_W:0]             pos_sum;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign out_load = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        case (paddr[2])
            REG_LENGTH: prdata = APB_DW'(r_length);
            REG_SPEED:  prdata = APB_DW'(r_speed);
            default:    prdata = '0;
        endcase
    end

    // position split and end-of-sample test
    assign ipos     = r_pos[POS_W-1:FRAC_BITS];
    assign frac     = r_pos[FRAC_BITS-1:0];
    assign tick_end = (r_length < LEN_W'(2))
                   || ((CMP_W'(ipos) + CMP_W'(1)) >= CMP_W'(r_length));

    // start search: prev begins at zero, so entry 0 only counts as a hit on a zero value
    assign seek_limit = (r_length < SKIP_LEN) ? r_length : SKIP_LEN;
    assign p_next     = LEN_W'(r_p) + LEN_W'(1);
    assign cur        = $signed(r_rdata);
    assign seek_hit   = (cur == '0) || (r_prev < 0 && cur > 0) || (cur < 0 && r_prev > 0);
    assign seek_done  = seek_hit || (p_next >= seek_limit);

    // interpolation, truncated toward zero
    assign diff    = DIFF_W'($signed(r_rdata)) - DIFF_W'(r_s1);
    assign num     = $signed({{(NUM_W-SAMPLE_W-FRAC_BITS){r_s1[SAMPLE_W-1]}}, r_s1,
                              {FRAC_BITS{1'b0}}}) + NUM_W'(r_prod);
    assign num_rnd = $unsigned(num)
                   + {{(NUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{num[NUM_W-1]}}};
    assign pos_sum = {1'b0, r_pos} + (POS_W+1)'(r_speed);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.req_type)
                        REQ_START: n_state = S_SEEK_RD;
                        REQ_TICK: begin
                            if (r_active) n_state = tick_end ? S_RESULT : S_TICK_RD1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SEEK_RD:  n_state = S_SEEK_CHK;
            S_SEEK_CHK: n_state = seek_done ? S_IDLE : S_SEEK_RD;
            S_TICK_RD1: n_state = S_TICK_RD2;
            S_TICK_RD2: n_state = S_TICK_MUL;
            S_TICK_MUL: n_state = S_TICK_SUM;
            S_TICK_SUM: n_state = S_RESULT;
            S_RESULT:   n_state = out_load ? S_IDLE : S_RESULT;
            default:    n_state = S_IDLE;
        endcase
    end

    // state outputs: input stall and store port
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        mem_we     = 1'b0;
        mem_addr   = i_in_data.write_addr;
        case (r_state)
            S_IDLE: begin
                mem_we   = in_xfer && (i_in_data.req_type == REQ_WRITE);
                mem_addr = i_in_data.write_addr;
            end
            S_SEEK_RD:  mem_addr = ADDR_W'(r_p);
            S_TICK_RD1: mem_addr = ipos[ADDR_W-1:0];
            S_TICK_RD2: mem_addr = ipos[ADDR_W-1:0] + ADDR_W'(1);
            default:    mem_addr = i_in_data.write_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_in_data.write_value;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_length    <= LENGTH_RESET;
            r_speed     <= SPEED_RESET;
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_LENGTH: r_length <= pwdata[LEN_W-1:0];
                    REG_SPEED:  r_speed  <= pwdata[SPEED_W-1:0];
                    default:    r_length <= r_length;
                endcase
            end
            if (r_state == S_IDLE && in_xfer && i_in_data.req_type == REQ_TICK
                    && r_active && tick_end) begin
                r_active <= 1'b0;
            end
            if (r_state == S_SEEK_CHK && seek_done) begin
                r_active <= 1'b1;
                r_pos    <= seek_hit ? (POS_W'(r_p) << FRAC_BITS)
                                     : (POS_W'(p_next) << FRAC_BITS);
            end
            if (r_state == S_TICK_SUM) begin
                r_pos <= pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p          <= '0;
                r_prev       <= '0;
                r_res_sample <= '0;
                r_res_play   <= 1'b0;
            end
            S_SEEK_CHK: begin
                r_p    <= P_W'(p_next);
                r_prev <= cur;
            end
            S_TICK_RD2: begin
                r_s1 <= $signed(r_rdata);
            end
            S_TICK_SUM: begin
                r_res_sample <= $signed(num_rnd[FRAC_BITS +: SAMPLE_W]);
                r_res_play   <= 1'b1;
            end
            default: begin
                r_p <= r_p;
            end
        endcase
        // second entry is on the read data here, first one sits in r_s1
        if (r_state == S_TICK_MUL) begin
            r_prod <= diff * $signed({1'b0, frac});
        end
        if (out_load) begin
            r_out_data.out_sample <= r_res_sample;
            r_out_data.is_playing <= r_res_play;
        end
    end

    `VRSP_ASSERT_NEXT(a_result_loads, out_load, o_out_valid,
        "result not presented after load")
    `VRSP_ASSERT_NOW(a_play_flag_match, out_load, r_active == r_res_play,
        "playing flag disagrees with active state")
    `VRSP_ASSERT_NEXT(a_idle_tick_drop,
        in_xfer && i_in_data.req_type == REQ_TICK && !r_active,
        r_state == S_IDLE, "tick while stopped did not stay idle")
    `VRSP_ASSERT_NEXT(a_write_one_cycle,
        in_xfer && i_in_data.req_type == REQ_WRITE,
        r_state == S_IDLE && !$past(o_in_stall), "sample write left idle")

endmodule

// File: sim/tb_variable_rate_sample_player.sv
// Self-checking testbench for the variable rate sample player.
`timescale 1ns / 1ps

module tb_variable_rate_sample_player;
    import vrsp_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam int SKIP = DEF_SKIP_LIMIT;
    localparam int SETTLE_CYCLES = 2 * DEF_SKIP_LIMIT + 32;
    localparam int ITEMS_TARGET = 800;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ADDR_LENGTH = {REG_LENGTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPEED = {REG_SPEED, 2'b00};
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    // Predicts the interpolated output samples and holds the ones still owed.
    class playback_scoreboard;
        bit signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
        bit                       mem_valid [STORE_DEPTH];
        bit [POS_W-1:0]           pos;
        bit                       playing;
        bit [LEN_W-1:0]           len_reg;
        bit [SPEED_W-1:0]         speed_reg;
        t_out_item                pending_samples [$];
        int unsigned              failures;

        function new();
            pos = '0;
            playing = 1'b0;
            len_reg = LENGTH_RESET;
            speed_reg = SPEED_RESET;
            failures = 0;
        endfunction

        function int search_limit();
            return (len_reg < SKIP) ? int'(len_reg) : SKIP;
        endfunction

        // Base entry a tick would read, or -1 when the tick reads nothing.
        function int tick_base();
            int ipos;
            ipos = int'(pos >> FRAC);
            if (!playing || len_reg < 2 || ipos >= int'(len_reg) - 1)
                return -1;
            return ipos;
        endfunction

        function int tick_gap();
            int b;
            b = tick_base();
            if (b < 0)
                return -1;
            if (!mem_valid[b])
                return b;
            if (!mem_valid[(b + 1) % STORE_DEPTH])
                return (b + 1) % STORE_DEPTH;
            return -1;
        endfunction

        // First never-written entry the start search would touch, or -1.
        function int start_gap();
            int limit;
            int p;
            int prev;
            int cur;
            limit = search_limit();
            if (!mem_valid[0])
                return 0;
            p = 0;
            cur = mem[0];
            do begin
                prev = cur;
                if (!mem_valid[p])
                    return p;
                cur = mem[p];
                if (cur == 0 || (prev < 0 && cur > 0) || (cur < 0 && prev > 0))
                    return -1;
                p++;
            end while (p < limit);
            return -1;
        endfunction

        function bit counts(t_in_item req);
            return req.req_type == REQ_WRITE || req.req_type == REQ_START ||
                   (req.req_type == REQ_TICK && playing);
        endfunction

        function logic signed [SAMPLE_W-1:0] blend(int s1, int s2, bit [FRAC-1:0] frac);
            longint num;
            int r;
            num = longint'(s1) * (longint'(1) << FRAC) + longint'(s2 - s1) * longint'(frac);
            // truncate toward zero
            r = (num >= 0) ? int'(num >>> FRAC) : -int'((-num) >>> FRAC);
            return r[SAMPLE_W-1:0];
        endfunction

        function void rewind();
            int limit;
            int p;
            int prev;
            int cur;
            limit = search_limit();
            p = 0;
            cur = mem[0];
            do begin
                prev = cur;
                cur = mem[p];
                if (cur == 0 || (prev < 0 && cur > 0) || (cur < 0 && prev > 0))
                    break;
                p++;
            end while (p < limit);
            pos = POS_W'(p) << FRAC;
            playing = 1'b1;
        endfunction

        function void note_request(t_in_item req);
            int base;
            t_out_item res;
            bit [POS_W:0] sum;
            case (req.req_type)
                REQ_WRITE: begin
                    mem[req.write_addr] = req.write_value;
                    mem_valid[req.write_addr] = 1'b1;
                end
                REQ_START: rewind();
                REQ_TICK: begin
                    if (playing) begin
                        base = tick_base();
                        if (base < 0) begin
                            playing = 1'b0;
                            res.out_sample = '0;
                            res.is_playing = 1'b0;
                        end else begin
                            res.out_sample = blend(mem[base], mem[(base + 1) % STORE_DEPTH],
                                                   pos[FRAC-1:0]);
                            res.is_playing = 1'b1;
                            sum = {1'b0, pos} + speed_reg;
                            pos = sum[POS_W] ? '1 : sum[POS_W-1:0];
                        end
                        pending_samples.push_back(res);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(t_out_item got);
            t_out_item want;
            if (pending_samples.size() == 0) begin
                $error("output transfer with no sample expected: out_sample %0d is_playing %0b",
                       got.out_sample, got.is_playing);
                failures++;
                return;
            end
            want = pending_samples.pop_front();
            if (got.out_sample !== want.out_sample) begin
                $error("out_sample: expected %0d, got %0d", want.out_sample, got.out_sample);
                failures++;
            end
            if (got.is_playing !== want.is_playing) begin
                $error("is_playing: expected %0b, got %0b", want.is_playing, got.is_playing);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    playback_scoreboard sb = new();
    bit quiet = 1'b0;
    bit run_neg = 1'b0;
    bit steady_fill = 1'b0;
    int item_count = 0;

    variable_rate_sample_player dut (.*);

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_sample(o_out_data);
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_in_item make_req(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                                          logic [SAMPLE_W-1:0] value);
        t_in_item req;
        req.req_type = kind;
        req.write_addr = addr;
        req.write_value = value;
        return req;
    endfunction

    // Sample values come in runs of one sign, with zeros and full-scale values mixed in.
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int roll;
        int mag;
        roll = $urandom_range(99);
        if (!steady_fill && roll < 5)
            return '0;
        if (!steady_fill && roll < 20)
            run_neg = ~run_neg;
        if (roll >= 20 && roll < 28)
            return run_neg ? 16'h8000 : 16'h7FFF;
        mag = (roll >= 28 && roll < 33) ? 1 : $urandom_range(1, 32767);
        return SAMPLE_W'(run_neg ? -mag : mag);
    endfunction

    // Starts and ends on a falling edge.
    task automatic send_request(t_in_item req);
        if (!quiet && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.counts(req))
            item_count++;
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic put_sample(logic [ADDR_W-1:0] addr, logic [SAMPLE_W-1:0] value);
        send_request(make_req(REQ_WRITE, addr, value));
    endtask

    // Entries the tick or the search will read are written first.
    task automatic tick_once();
        int a;
        a = sb.tick_gap();
        while (a >= 0) begin
            put_sample(ADDR_W'(a), next_sample());
            a = sb.tick_gap();
        end
        send_request(make_req(REQ_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom)));
    endtask

    task automatic start_play();
        int a;
        a = sb.start_gap();
        while (a >= 0) begin
            put_sample(ADDR_W'(a), next_sample());
            a = sb.start_gap();
        end
        send_request(make_req(REQ_START, ADDR_W'($urandom), SAMPLE_W'($urandom)));
    endtask

    task automatic noise_item();
        case ($urandom_range(3))
            0: send_request(make_req(REQ_UNUSED, ADDR_W'($urandom), SAMPLE_W'($urandom)));
            1: put_sample(ADDR_W'($urandom), SAMPLE_W'($urandom));
            2: tick_once();
            default: start_play();
        endcase
    endtask

    // A start search runs with no output, so allow for the longest one.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_registers(int len, logic [SPEED_W-1:0] spd);
        settle();
        reg_write(ADDR_LENGTH, APB_DW'(len));
        sb.len_reg = LEN_W'(len);
        reg_write(ADDR_SPEED, APB_DW'(spd));
        sb.speed_reg = spd;
    endtask

    task automatic random_phase(int phase_no);
        int roll;
        int len;
        int n_wr;
        int n_ticks;
        int k;
        logic [SPEED_W-1:0] spd;
        steady_fill = (phase_no == 3);
        if (steady_fill || $urandom_range(3) != 0) begin
            roll = $urandom_range(99);
            if (steady_fill)
                len = $urandom_range(SKIP, 2000);
            else if (roll < 8)
                len = $urandom_range(0, 1);
            else if (roll < 50)
                len = $urandom_range(2, 16);
            else if (roll < 80)
                len = $urandom_range(17, 120);
            else if (roll < 92)
                len = $urandom_range(121, 700);
            else
                len = ($urandom_range(2) == 0) ? STORE_DEPTH : $urandom_range(60000, STORE_DEPTH);
            roll = $urandom_range(99);
            if (roll < 10)
                spd = '0;
            else if (roll < 20)
                spd = SPEED_MAX;
            else if (roll < 40)
                spd = SPEED_RESET;
            else if (roll < 70)
                spd = SPEED_W'($urandom_range(1, 24'h1FFFF));
            else if (roll < 85)
                spd = SPEED_W'($urandom_range(1, 24'hFFFF));
            else
                spd = SPEED_W'($urandom);
            set_registers(len, spd);
        end
        n_wr = steady_fill ? SKIP : $urandom_range(0, 24);
        for (k = 0; k < n_wr; k++) begin
            if (!steady_fill && $urandom_range(19) == 0)
                noise_item();
            put_sample(ADDR_W'(k), next_sample());
        end
        if (steady_fill || !sb.playing || $urandom_range(4) != 0)
            start_play();
        n_ticks = $urandom_range(1, 60);
        for (k = 0; k < n_ticks && sb.playing; k++) begin
            if ($urandom_range(19) == 0)
                noise_item();
            tick_once();
        end
    endtask

    initial begin
        int guard;
        int phase_no;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: length 0, unit speed
        tick_once();
        send_request(make_req(REQ_UNUSED, 16'hA5C3, 16'h5A3C));
        put_sample(16'd0, 16'h7FFF);
        start_play();
        tick_once();
        set_registers(1, SPEED_RESET);
        start_play();
        tick_once();

        // sign change at entry 2, half-rate playback, then speed changes mid-playback
        set_registers(6, 24'h008000);
        put_sample(16'd1, 16'h7FFF);
        put_sample(16'd2, 16'h8000);
        put_sample(16'd3, 16'h7FFF);
        put_sample(16'd4, 16'h0000);
        put_sample(16'd5, 16'hFFFF);
        put_sample(16'hFFFF, 16'hFFFF);
        start_play();
        repeat (3) tick_once();
        set_registers(6, '0);
        repeat (2) tick_once();
        set_registers(6, SPEED_MAX);
        repeat (2) tick_once();

        // full store at top speed: the position add saturates near the end
        set_registers(STORE_DEPTH, SPEED_MAX);
        for (guard = 0; guard < 5; guard++)
            put_sample(ADDR_W'(guard), SAMPLE_W'($urandom_range(1, 32767)));
        put_sample(16'd5, 16'h0000);
        start_play();
        guard = 0;
        while (sb.playing && guard < 400) begin
            tick_once();
            guard++;
        end

        item_count = 0;
        phase_no = 0;
        while (item_count < ITEMS_TARGET) begin
            quiet = item_count >= 300 && item_count < 500;
            random_phase(phase_no);
            phase_no++;
        end
        quiet = 1'b0;

        settle();
        if (sb.failures == 0 && sb.pending_samples.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
